@@ rtl/ble_frame_reassembler_assert.svh @@
// Assertion macros shared by the frame reassembler modules.
`ifndef BLE_FRAME_REASSEMBLER_ASSERT_SVH
`define BLE_FRAME_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BLEFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame reassembler check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BLEFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame reassembler check failed");

`endif

@@ rtl/blefr_pkg.sv @@
// Types, codes and helper functions of the frame reassembler.
package blefr_pkg;

   localparam int MSG_BYTES_DEFAULT = 1024;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_DONE    = 2'd1;
   localparam logic [1:0] EV_SEQ_ERR = 2'd2;
   localparam logic [1:0] EV_READ    = 2'd3;

   localparam logic [1:0] KIND_PING    = 2'd0;
   localparam logic [1:0] KIND_MSG     = 2'd1;
   localparam logic [1:0] KIND_CANCEL  = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   localparam logic [6:0] CMD_PING   = 7'h01;
   localparam logic [6:0] CMD_MSG    = 7'h03;
   localparam logic [6:0] CMD_CANCEL = 7'h3E;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_HEADER  = 2'd1,
      MODE_PAYLOAD = 2'd2
   } blefr_mode_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] frame_byte;
      logic       frame_first;
      logic       frame_last;
      logic [9:0] read_index;
   } blefr_req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  command;
      logic [1:0]  command_kind;
      logic [15:0] message_length;
      logic        overflow;
      logic [7:0]  read_data;
   } blefr_rsp_type;

   // Class of a command from its low seven bits.
   function automatic logic [1:0] cmd_kind(input logic [7:0] cmd);
      logic [1:0] kind;
      case (cmd[6:0])
         CMD_PING:   kind = KIND_PING;
         CMD_MSG:    kind = KIND_MSG;
         CMD_CANCEL: kind = KIND_CANCEL;
         default:    kind = KIND_INVALID;
      endcase
      return kind;
   endfunction

endpackage

@@ rtl/blefr_store.sv @@
// Message byte store: one write port and one registered read port.
module blefr_store #(
   parameter int MSG_BYTES = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MSG_BYTES)-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(MSG_BYTES)-1:0] rd_addr,
   output logic [7:0]                   rd_data
);
   import blefr_pkg::*;

   logic [7:0] mem [MSG_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/blefr_parser.sv @@
// Frame parser: header capture, sequence check, length tracking and store control.
`include "ble_frame_reassembler_assert.svh"

module blefr_parser #(
   parameter int MSG_BYTES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  blefr_pkg::blefr_req_type      req,
   output logic                          wr_en,
   output logic [$clog2(MSG_BYTES)-1:0]  wr_addr,
   output logic [7:0]                    wr_data,
   output logic                          rd_en,
   output logic [$clog2(MSG_BYTES)-1:0]  rd_addr,
   output logic                          rd_ok,
   output blefr_pkg::blefr_rsp_type      rsp
);
   import blefr_pkg::*;

   localparam int ADDR_W = $clog2(MSG_BYTES);
   localparam logic [16:0] CAPACITY = 17'(MSG_BYTES);

   blefr_mode_type mode_ff, mode_in;
   logic [1:0]  hpos_ff, hpos_in;
   logic [7:0]  pend_cmd_ff, pend_cmd_in;
   logic [7:0]  pend_hi_ff, pend_hi_in;
   logic [7:0]  msg_cmd_ff, msg_cmd_in;
   logic [15:0] decl_ff, decl_in;
   logic [7:0]  exp_seq_ff, exp_seq_in;
   logic [15:0] count_ff, count_in;
   logic        open_ff, open_in;

   logic        byte_go, init_start, cont_ok, seq_err;
   logic        in_hdr, hdr_hi, hdr_take, in_pay, pay_store, eof_check, done;
   logic        open_pre;
   logic [15:0] new_len;

   // Decode of the accepted byte against the current frame state.
   always_comb begin
      byte_go    = accept && (req.req_type == REQ_FRAME);
      init_start = byte_go && req.frame_first && req.frame_byte[7];
      cont_ok    = byte_go && req.frame_first && !req.frame_byte[7] && open_ff &&
                   (req.frame_byte == exp_seq_ff);
      seq_err    = byte_go && req.frame_first && !req.frame_byte[7] && open_ff &&
                   (req.frame_byte != exp_seq_ff);
      in_hdr     = byte_go && !req.frame_first && (mode_ff == MODE_HEADER);
      hdr_hi     = in_hdr && (hpos_ff == 2'd1);
      hdr_take   = in_hdr && (hpos_ff != 2'd1);
      in_pay     = byte_go && !req.frame_first && (mode_ff == MODE_PAYLOAD);
      pay_store  = in_pay && open_ff && (count_ff < decl_ff);
      new_len    = {pend_hi_ff, req.frame_byte};
      eof_check  = req.frame_last && (cont_ok || hdr_take || in_pay);
      open_pre   = hdr_take || open_ff;
      decl_in    = hdr_take ? new_len : decl_ff;
      count_in   = hdr_take ? 16'd0 : (count_ff + {15'd0, pay_store});
      done       = eof_check && open_pre && (count_in >= decl_in);
   end

   // Next state.
   always_comb begin
      mode_in     = mode_ff;
      hpos_in     = hpos_ff;
      pend_cmd_in = pend_cmd_ff;
      pend_hi_in  = pend_hi_ff;
      msg_cmd_in  = msg_cmd_ff;
      exp_seq_in  = exp_seq_ff;
      open_in     = done ? 1'b0 : open_pre;
      if (byte_go) begin
         if (init_start) begin
            pend_cmd_in = req.frame_byte;
            hpos_in     = 2'd1;
            mode_in     = req.frame_last ? MODE_IDLE : MODE_HEADER;
         end else if (req.frame_first) begin
            mode_in = (cont_ok && !req.frame_last) ? MODE_PAYLOAD : MODE_IDLE;
            if (cont_ok) begin
               exp_seq_in = exp_seq_ff + 8'd1;
            end
         end else if (hdr_hi) begin
            pend_hi_in = req.frame_byte;
            hpos_in    = 2'd2;
            mode_in    = req.frame_last ? MODE_IDLE : MODE_HEADER;
         end else if (hdr_take) begin
            msg_cmd_in = pend_cmd_ff;
            exp_seq_in = 8'd0;
            hpos_in    = 2'd0;
            mode_in    = req.frame_last ? MODE_IDLE : MODE_PAYLOAD;
         end else if (in_pay) begin
            mode_in = req.frame_last ? MODE_IDLE : MODE_PAYLOAD;
         end else begin
            mode_in = MODE_IDLE;
         end
      end
   end

   // Outputs: result fields and store accesses.
   always_comb begin
      rsp       = '0;
      wr_en     = pay_store && ({1'b0, count_ff} < CAPACITY);
      wr_addr   = ADDR_W'(count_ff);
      wr_data   = req.frame_byte;
      rd_en     = accept && (req.req_type == REQ_READ);
      rd_addr   = ADDR_W'(req.read_index);
      rd_ok     = rd_en && (17'(req.read_index) < CAPACITY);
      if (rd_en) begin
         rsp.event_res = EV_READ;
      end else if (seq_err) begin
         rsp.event_res = EV_SEQ_ERR;
      end else if (done) begin
         rsp.event_res      = EV_DONE;
         rsp.command        = msg_cmd_in;
         rsp.command_kind   = cmd_kind(msg_cmd_in);
         rsp.message_length = decl_in;
         rsp.overflow       = ({1'b0, decl_in} > CAPACITY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         hpos_ff     <= 2'd0;
         pend_cmd_ff <= 8'd0;
         pend_hi_ff  <= 8'd0;
         msg_cmd_ff  <= 8'd0;
         decl_ff     <= 16'd0;
         exp_seq_ff  <= 8'd0;
         count_ff    <= 16'd0;
         open_ff     <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         hpos_ff     <= hpos_in;
         pend_cmd_ff <= pend_cmd_in;
         pend_hi_ff  <= pend_hi_in;
         msg_cmd_ff  <= msg_cmd_in;
         decl_ff     <= decl_in;
         exp_seq_ff  <= exp_seq_in;
         count_ff    <= count_in;
         open_ff     <= open_in;
      end
   end

   `BLEFR_ASSERT_NOW(a_count_bounded, open_ff, count_ff <= decl_ff)
   `BLEFR_ASSERT_NOW(a_write_in_payload, wr_en, (mode_ff == MODE_PAYLOAD) && open_ff)
   `BLEFR_ASSERT_NEXT(a_done_closes, done, !open_ff)

endmodule

@@ rtl/ble_frame_reassembler.sv @@
// Top level of the frame reassembler: parser, message store and result register.
//
// The req_ channel carries one transfer per received frame byte or per store
// read request (req_data.req_type selects which). Frame bytes carry first and
// last marks. Every accepted transfer yields exactly one transfer on the rsp_
// channel: a completion with command, class, length and overflow flag, an
// invalid-sequence error, read data, or an empty result.
// A result is offered in the cycle after its request is taken. Throughput
// is one transfer per cycle while results are consumed; each byte needs one
// access to the single-port-write message memory, whose read port is registered.
// The result register holds one finished result. While it is full and
// rsp_ready is low, req_ready is low and nothing is taken; a consumed result
// is replaced in the same cycle by the next one.
// A synchronous reset clears the frame state and the result valid flag; the
// message memory is not cleared, and its contents are defined only where
// payload bytes were written since power up.
// A store write lands at the edge that accepts the byte, so a read request in
// any later cycle sees it; two accesses never meet in one cycle.
`include "ble_frame_reassembler_assert.svh"

module ble_frame_reassembler #(
   parameter int MSG_BYTES = blefr_pkg::MSG_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  blefr_pkg::blefr_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output blefr_pkg::blefr_rsp_type rsp_data
);
   import blefr_pkg::*;

   localparam int ADDR_W = $clog2(MSG_BYTES);

   logic              accept;
   logic              wr_en, rd_en, rd_ok;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;
   blefr_rsp_type     result;

   blefr_rsp_type     result_ff;
   logic              rd_ok_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // The slot frees when its result is taken, so a new transfer can enter then.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   blefr_parser #(
      .MSG_BYTES(MSG_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_ok  (rd_ok),
      .rsp    (result)
   );

   blefr_store #(
      .MSG_BYTES(MSG_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; the memory read data register updates on the same edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
         rd_ok_ff  <= rd_ok;
      end
   end

   // Out-of-range reads and non-read results return zero data.
   always_comb begin
      rsp_data           = result_ff;
      rsp_data.read_data = rd_ok_ff ? rd_data : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

   `BLEFR_ASSERT_NEXT(a_accept_gives_result, accept, rsp_valid_ff)
   `BLEFR_ASSERT_NEXT(a_result_kept, rsp_valid_ff && !rsp_ready, rsp_valid_ff)
   `BLEFR_ASSERT_NOW(a_read_flag_event, rsp_valid_ff && rd_ok_ff, result_ff.event_res == EV_READ)

endmodule

@@ dv/ble_frame_reassembler_checker.sv @@
// Checker for the frame reassembler: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module ble_frame_reassembler_checker #(
   parameter int MSG_BYTES = blefr_pkg::MSG_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  blefr_pkg::blefr_req_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  blefr_pkg::blefr_rsp_type rsp_data,
   output int                       fail_count,
   output int                       outstanding,
   output int                       completions,
   output int                       overflows,
   output int                       seq_errors
);
   import blefr_pkg::*;

   localparam int ADDR_W = $clog2(MSG_BYTES);

   // Shadow of the reassembly state.
   blefr_mode_type mode;
   logic [1:0]     hdr_pos;
   logic [7:0]     pend_cmd;
   logic [7:0]     pend_len_hi;
   logic [7:0]     msg_cmd;
   logic [15:0]    decl_len;
   logic [7:0]     exp_seq;
   logic [15:0]    rcv_count;
   logic           msg_open;
   logic [7:0]     store_mem [MSG_BYTES];

   blefr_rsp_type  results_due [$];
   blefr_rsp_type  new_rsp;
   blefr_rsp_type  due_rsp;

   function automatic logic [1:0] command_class(input logic [7:0] cmd);
      logic [1:0] cls;
      cls = KIND_INVALID;
      if (cmd[6:0] == CMD_PING) cls = KIND_PING;
      else if (cmd[6:0] == CMD_MSG) cls = KIND_MSG;
      else if (cmd[6:0] == CMD_CANCEL) cls = KIND_CANCEL;
      return cls;
   endfunction

   // Length check at the end of a frame.
   task automatic close_frame(inout blefr_rsp_type res);
      mode = MODE_IDLE;
      if (msg_open && rcv_count >= decl_len) begin
         msg_open           = 1'b0;
         res.event_res      = EV_DONE;
         res.command        = msg_cmd;
         res.command_kind   = command_class(msg_cmd);
         res.message_length = decl_len;
         res.overflow       = (int'(decl_len) > MSG_BYTES);
      end
   endtask

   task automatic reassemble(input blefr_req_type r, output blefr_rsp_type res);
      res = '0;
      if (r.req_type == REQ_READ) begin
         res.event_res = EV_READ;
         res.read_data = (int'(r.read_index) < MSG_BYTES) ?
                         store_mem[ADDR_W'(r.read_index)] : 8'h00;
      end else if (r.frame_first) begin
         if (r.frame_byte[7]) begin
            pend_cmd = r.frame_byte;
            hdr_pos  = 2'd1;
            mode     = r.frame_last ? MODE_IDLE : MODE_HEADER;
         end else if (!msg_open) begin
            mode = MODE_IDLE;
         end else if (r.frame_byte != exp_seq) begin
            mode          = MODE_IDLE;
            res.event_res = EV_SEQ_ERR;
         end else begin
            exp_seq = exp_seq + 8'd1;
            mode    = MODE_PAYLOAD;
            if (r.frame_last) close_frame(res);
         end
      end else if (mode == MODE_HEADER) begin
         if (hdr_pos == 2'd1) begin
            pend_len_hi = r.frame_byte;
            hdr_pos     = 2'd2;
            if (r.frame_last) mode = MODE_IDLE;
         end else begin
            msg_cmd   = pend_cmd;
            decl_len  = {pend_len_hi, r.frame_byte};
            exp_seq   = 8'd0;
            rcv_count = 16'd0;
            msg_open  = 1'b1;
            hdr_pos   = 2'd0;
            mode      = MODE_PAYLOAD;
            if (r.frame_last) close_frame(res);
         end
      end else if (mode == MODE_PAYLOAD) begin
         if (msg_open && rcv_count < decl_len) begin
            if (int'(rcv_count) < MSG_BYTES) store_mem[ADDR_W'(rcv_count)] = r.frame_byte;
            rcv_count = rcv_count + 16'd1;
         end
         if (r.frame_last) close_frame(res);
      end else begin
         mode = MODE_IDLE;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode        = MODE_IDLE;
         hdr_pos     = 2'd0;
         pend_cmd    = 8'd0;
         pend_len_hi = 8'd0;
         msg_cmd     = 8'd0;
         decl_len    = 16'd0;
         exp_seq     = 8'd0;
         rcv_count   = 16'd0;
         msg_open    = 1'b0;
         results_due.delete();
         outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            reassemble(req_data, new_rsp);
            results_due = {results_due, new_rsp};
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               due_rsp = results_due.pop_front();
               check_field("event_res", 16'(due_rsp.event_res), 16'(rsp_data.event_res));
               check_field("command", 16'(due_rsp.command), 16'(rsp_data.command));
               check_field("command_kind", 16'(due_rsp.command_kind),
                           16'(rsp_data.command_kind));
               check_field("message_length", due_rsp.message_length,
                           rsp_data.message_length);
               check_field("overflow", 16'(due_rsp.overflow), 16'(rsp_data.overflow));
               check_field("read_data", 16'(due_rsp.read_data), 16'(rsp_data.read_data));
               if (due_rsp.event_res == EV_DONE) completions++;
               if (due_rsp.event_res == EV_DONE && due_rsp.overflow) overflows++;
               if (due_rsp.event_res == EV_SEQ_ERR) seq_errors++;
            end
         end
         outstanding <= results_due.size();
      end
   end

endmodule

@@ dv/ble_frame_reassembler_test.sv @@
// Testbench top for the frame reassembler: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module ble_frame_reassembler_test;
   import blefr_pkg::*;

   // A stretch this long without any transfer on either channel means the
   // block has hung.
   localparam int IDLE_LIMIT  = 2000;
   // Number of request transfers, frame bytes and reads together, the run aims for.
   localparam int ITEM_TARGET = 700;
   // Payload length of the first clean message; reads stay below it.
   localparam int FILL_BYTES  = 96;

   logic          clock;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   blefr_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   blefr_rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int completions;
   int overflows;
   int seq_errors;

   // Sender bookkeeping.
   int         burst_left;
   int         frame_bytes_sent;
   int         reads_sent;
   int         read_span;
   logic [7:0] frame_q [$];

   // Receiver stall pattern.
   int stall_left;
   int rx_mode;
   int rx_cycles;

   // Watchdog.
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   ble_frame_reassembler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The checker sits beside the block, watches both channels and keeps its
   // own picture of the reassembly state and the message store.
   ble_frame_reassembler_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .completions (completions),
      .overflows   (overflows),
      .seq_errors  (seq_errors)
   );

   // The receiver moves between three behaviors, picked at random: always
   // ready, ready with a chance of two in three, and mostly ready with an
   // occasional stall. The switch points drift against the sender's bursts,
   // so stalls land on every phase of a frame.
   always @(posedge clock) begin
      rx_cycles++;
      if (rx_cycles >= 150) begin
         rx_cycles = 0;
         rx_mode   = $urandom_range(0, 2);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rx_mode == 0) begin
         rsp_ready <= 1'b1;
      end else if (rx_mode == 1) begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 20);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Any cycle with a transfer on either channel resets the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offers one item and returns at the edge that accepts it. The sender runs
   // in bursts; at the end of a burst valid may drop for a random gap. Valid is
   // only lowered when a real gap follows, so a back-to-back item never sees
   // valid lowered and raised again within the same time step.
   task automatic send_item(input blefr_req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.req_type == REQ_READ) reads_sent++;
      else frame_bytes_sent++;
   endtask

   // Read request; the frame fields are don't-care and get random values.
   task automatic send_read(input logic [9:0] index);
      blefr_req_type item;
      item             = blefr_req_type'($urandom);
      item.req_type    = REQ_READ;
      item.read_index  = index;
      send_item(item);
   endtask

   // Sends the bytes queued in frame_q as one frame. The first-byte mark is
   // optional so stray bytes can be produced too; the last-byte mark goes on
   // the final byte only when the frame is closed. Once the fill message is
   // through, read requests inside the filled span are slipped in between
   // bytes at random.
   task automatic send_frame(input bit open_mark, input bit close);
      blefr_req_type item;
      for (int i = 0; i < frame_q.size(); i++) begin
         if (read_span > 0 && $urandom_range(0, 11) == 0) begin
            send_read(10'($urandom_range(0, read_span - 1)));
         end
         item.req_type    = REQ_FRAME;
         item.frame_byte  = frame_q[i];
         item.frame_first = open_mark && (i == 0);
         item.frame_last  = close && (i == frame_q.size() - 1);
         item.read_index  = 10'($urandom);
         send_item(item);
      end
      frame_q.delete();
   endtask

   // Lets the block run dry: valid stays low until every result is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One message: an initialization frame with command and length, then
   // continuation frames with sequence numbers counting up from zero. Payload
   // per frame is random up to chunk_max. In a clean message every frame is
   // well formed; otherwise faults are mixed in: frames with the wrong
   // sequence number, short initialization frames that must leave the message
   // alone, frames cut off by the next first-byte mark, and surplus bytes.
   // Messages with faults that would need many frames are abandoned after 40 of them,
   // which also keeps sequence numbers below the init-frame range.
   task automatic send_message(input logic [7:0] cmd, input logic [15:0] len,
                               input int chunk_max, input bit clean);
      int sent;
      int take;
      int seq;
      int frames;
      bit cut;
      sent   = 0;
      seq    = 0;
      frames = 0;
      frame_q = '{cmd, len[15:8], len[7:0]};
      take = clean ? $urandom_range(9, chunk_max) : $urandom_range(0, chunk_max);
      if (take > int'(len)) take = int'(len);
      repeat (take) frame_q = {frame_q, 8'($urandom)};
      sent = take;
      if (!clean && sent == int'(len) && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 3)) frame_q = {frame_q, 8'($urandom)};
      end
      send_frame(1'b1, 1'b1);
      while (sent < int'(len) && (clean || frames < 40)) begin
         if (!clean) begin
            case ($urandom_range(0, 15))
               0: begin
                  // Wrong sequence number, still a continuation frame.
                  frame_q = '{8'((seq + $urandom_range(1, 127)) % 128)};
                  repeat ($urandom_range(0, 2)) frame_q = {frame_q, 8'($urandom)};
                  send_frame(1'b1, 1'b1);
               end
               1: begin
                  // Initialization frame that ends before its length is known.
                  frame_q = '{8'h80 | 8'($urandom)};
                  if ($urandom_range(0, 1) == 1) frame_q = {frame_q, 8'($urandom)};
                  send_frame(1'b1, 1'b1);
               end
               default: ;
            endcase
         end
         frame_q = '{8'(seq)};
         take = clean ? $urandom_range(9, chunk_max) : $urandom_range(0, chunk_max);
         if (take > int'(len) - sent) take = int'(len) - sent;
         repeat (take) frame_q = {frame_q, 8'($urandom)};
         sent += take;
         if (!clean && sent == int'(len) && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) frame_q = {frame_q, 8'($urandom)};
         end
         cut = !clean && ($urandom_range(0, 9) == 0);
         send_frame(1'b1, !cut);
         seq++;
         frames++;
      end
   endtask

   // Junk between messages: short frames with a random first byte, orphan
   // continuations, bytes without a first-byte mark, open or unclosed frames.
   task automatic send_noise();
      repeat ($urandom_range(1, 4)) frame_q = {frame_q, 8'($urandom)};
      send_frame($urandom_range(0, 3) != 0, $urandom_range(0, 1) == 1);
   endtask

   initial begin
      logic [6:0]  cls;
      logic [15:0] len;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases with the store still unwritten, so no reads yet.
      // A byte without a first mark while idle is ignored.
      frame_q = '{8'hFF};
      send_frame(1'b0, 1'b1);
      // Continuation frame with no message open is dropped silently.
      frame_q = '{8'h00, 8'h5A};
      send_frame(1'b1, 1'b1);
      // Initialization frames ending after one and after two bytes.
      frame_q = '{8'h81};
      send_frame(1'b1, 1'b1);
      frame_q = '{8'hBE, 8'h00};
      send_frame(1'b1, 1'b1);
      // Zero-length ping completes at the end of its initialization frame.
      frame_q = '{8'h81, 8'h00, 8'h00};
      send_frame(1'b1, 1'b1);

      // A clean message that writes the low part of the store. The store is
      // never cleared, so every later read inside that span sees a written
      // entry.
      send_message(8'h83, 16'(FILL_BYTES), 16, 1'b1);
      drain();
      read_span = FILL_BYTES;

      // Reads at both ends of the filled span.
      send_read(10'd0);
      send_read(10'(FILL_BYTES - 1));
      // Cancel whose payload fits in the initialization frame.
      frame_q = '{8'hBE, 8'h00, 8'h02, 8'h00, 8'hFF};
      send_frame(1'b1, 1'b1);
      // Largest declared length with an invalid command; stays open.
      frame_q = '{8'hFF, 8'hFF, 8'hFF};
      send_frame(1'b1, 1'b1);
      // Wrong sequence number while that message is open.
      frame_q = '{8'h05, 8'h11};
      send_frame(1'b1, 1'b1);
      // An unfinished header abandoned by a new one, which replaces the open
      // message; its single payload byte then comes in a continuation frame.
      frame_q = '{8'h83, 8'h00};
      send_frame(1'b1, 1'b0);
      frame_q = '{8'h83, 8'h00, 8'h01};
      send_frame(1'b1, 1'b1);
      frame_q = '{8'h00, 8'h7F};
      send_frame(1'b1, 1'b1);
      // Surplus payload beyond the declared length.
      frame_q = '{8'h83, 8'h00, 8'h01, 8'hAB, 8'hCD};
      send_frame(1'b1, 1'b1);
      send_read(10'd0);

      // Random part: mostly well-formed messages with random content and
      // injected faults, some noise in between, and an occasional full drain.
      while (frame_bytes_sent + reads_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            send_noise();
         end else begin
            case ($urandom_range(0, 3))
               0:       cls = CMD_PING;
               1:       cls = CMD_MSG;
               2:       cls = CMD_CANCEL;
               default: cls = 7'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0:       len = 16'd0;
               1:       len = 16'($urandom_range(25, 160));
               2:       len = 16'($urandom);
               default: len = 16'($urandom_range(1, 24));
            endcase
            send_message({1'b1, cls}, len, $urandom_range(1, 12), 1'b0);
         end
         if ($urandom_range(0, 24) == 0) drain();
      end

      // Wait for every outstanding result, then let the clock run on so that
      // anything the block might still emit on its own is seen.
      drain();
      repeat (4) @(posedge clock);

      $display("Sent %0d frame bytes and %0d read requests.", frame_bytes_sent, reads_sent);
      $display("Saw %0d completed messages (%0d overflowing) and %0d sequence errors.",
               completions, overflows, seq_errors);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, outstanding);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
